// ----- design/ipf_pkg.sv -----
// Package for the integer printf formatter: constants, codes and types.
// No dependencies.
package ipf_pkg;
  localparam int MAX_FIELD = 48;
  localparam int VAL_W = 64;
  localparam int CNT_W = $clog2(MAX_FIELD + 3);
  localparam int NDIG_W = 5;
  localparam int DIG_MAX = 24;

  localparam logic [2:0] CONV_D = 3'd0;
  localparam logic [2:0] CONV_I = 3'd1;
  localparam logic [2:0] CONV_O = 3'd2;
  localparam logic [2:0] CONV_U = 3'd3;
  localparam logic [2:0] CONV_X = 3'd4;
  localparam logic [2:0] CONV_XU = 3'd5;

  localparam logic [1:0] LEN_INT = 2'd0;
  localparam logic [1:0] LEN_H = 2'd1;

  localparam logic [2:0] REG_CONV = 3'd0;
  localparam logic [2:0] REG_LEN = 3'd1;
  localparam logic [2:0] REG_FLAGS = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_PREC = 3'd4;
  localparam logic [2:0] REG_PGIVEN = 3'd5;

  localparam int FL_MINUS = 0;
  localparam int FL_PLUS = 1;
  localparam int FL_SPACE = 2;
  localparam int FL_SHARP = 3;
  localparam int FL_ZERO = 4;

  typedef struct packed {
    logic [2:0] conversion;
    logic [1:0] length_modifier;
    logic [4:0] format_flags;
    logic [5:0] field_width;
    logic [5:0] precision;
    logic       precision_given;
  } cfg_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h37 + {4'd0, d};
    else c = 8'h57 + {4'd0, d};
    return c;
  endfunction
endpackage

// ----- design/ipf_divider.sv -----
// Bit-serial divider: divides a 64-bit magnitude by a small radix, one bit a cycle.
// Depends on ipf_pkg.
module ipf_divider import ipf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [4:0]       radix,
  output logic             done,
  output logic [VAL_W-1:0] quotient,
  output logic [3:0]       remainder
);
  logic [VAL_W-1:0] quo;
  logic [4:0]       rem;
  logic [6:0]       cnt;
  logic             running;
  logic [5:0]       trial;

  assign trial = {rem, quo[VAL_W-1]};

  // restoring division, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        quo <= dividend;
        rem <= '0;
        cnt <= 7'(VAL_W);
      end else if (running) begin
        if (trial >= {1'b0, radix}) begin
          rem <= 5'(trial - {1'b0, radix});
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          rem <= trial[4:0];
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem[3:0];
endmodule

// ----- design/integer_printf_formatter_core.sv -----
// Integer printf formatter top level: config registers, digit sequencer, char emitter.
// Depends on ipf_pkg and ipf_divider.
// Digits: hex/octal come from shifts, decimal from the bit-serial divider; the text
// then goes out at one character per cycle.
// Throughput: one value at a time; busy is high from acceptance to the last strobe.
// Reset: synchronous, registers return to their reset values, no output pending.
module integer_printf_formatter_core import ipf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [5:0]       cfg_data,
  output logic             strobe,
  output logic [7:0]       out_char,
  output logic             is_empty,
  output logic             is_last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIG = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_PLAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  cfg_t cfg;
  logic [2:0] state;
  logic [2:0] kind;
  logic is_sgn, upper, minus, zero_pad;
  logic [4:0] radix;
  logic [VAL_W-1:0] mag, mask, v, sbit;
  logic [VAL_W-1:0] quo;
  logic [7:0] digs [DIG_MAX];
  logic [NDIG_W-1:0] ndig;
  logic mag_zero;
  logic [1:0] plen;
  logic [7:0] pre0, pre1;
  logic [CNT_W-1:0] pad, zeros, pos, total;
  logic [NDIG_W-1:0] dpos;
  logic [CNT_W-1:0] prec, wid;
  logic div_start, div_done;
  logic [VAL_W-1:0] div_q;
  logic [3:0] div_r;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{conversion: 3'd0, length_modifier: 2'd0, format_flags: 5'd0,
               field_width: 6'd0, precision: 6'd1, precision_given: 1'b0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONV: cfg.conversion <= cfg_data[2:0];
        REG_LEN: cfg.length_modifier <= cfg_data[1:0];
        REG_FLAGS: cfg.format_flags <= cfg_data[4:0];
        REG_WIDTH: cfg.field_width <= cfg_data;
        REG_PREC: cfg.precision <= cfg_data;
        REG_PGIVEN: cfg.precision_given <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decoded format
  always_comb begin
    kind = (cfg.conversion <= CONV_XU) ? cfg.conversion : CONV_U;
    is_sgn = (kind == CONV_D) || (kind == CONV_I);
    radix = (kind == CONV_O) ? 5'd8 : ((kind >= CONV_X) ? 5'd16 : 5'd10);
    upper = (kind == CONV_XU);
    minus = cfg.format_flags[FL_MINUS];
    zero_pad = cfg.format_flags[FL_ZERO] && !minus && !cfg.precision_given;
    prec = cfg.precision_given ?
           ((cfg.precision > 6'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(cfg.precision))
           : CNT_W'(1);
    wid = (cfg.field_width > 6'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(cfg.field_width);
    case (cfg.length_modifier)
      LEN_INT: begin mask = 64'hFFFF_FFFF; sbit = 64'h8000_0000; end
      LEN_H: begin mask = 64'hFFFF; sbit = 64'h8000; end
      default: begin mask = '1; sbit = 64'h8000_0000_0000_0000; end
    endcase
    v = value & mask;
  end

  ipf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(quo), .radix(radix),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // digit source: shifts for power-of-two radix (one digit per cycle), divider for decimal
  logic [3:0] fast_dig;
  logic [VAL_W-1:0] fast_q;
  always_comb begin
    if (radix == 5'd16) begin
      fast_dig = quo[3:0];
      fast_q = quo >> 4;
    end else begin
      fast_dig = {1'b0, quo[2:0]};
      fast_q = quo >> 3;
    end
  end

  logic [CNT_W-1:0] len_c, zeros_c, pad_c;
  logic lead_zero;
  always_comb begin
    zeros_c = (prec > CNT_W'(ndig)) ? prec - CNT_W'(ndig) : '0;
    lead_zero = (zeros_c != 0) || ((ndig != 0) && mag_zero);
    if (cfg.format_flags[FL_SHARP] && (kind == CONV_O) && !lead_zero)
      zeros_c = zeros_c + CNT_W'(1);
    len_c = CNT_W'(plen) + zeros_c + CNT_W'(ndig);
    pad_c = (wid > len_c) ? wid - len_c : '0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      div_start <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          if (is_sgn && ((v & sbit) != 0)) begin
            mag <= (~v + 64'd1) & mask;
            quo <= (~v + 64'd1) & mask;
            plen <= 2'd1; pre0 <= "-";
          end else begin
            mag <= v;
            quo <= v;
            plen <= 2'd0;
            if (is_sgn && cfg.format_flags[FL_PLUS]) begin plen <= 2'd1; pre0 <= "+"; end
            else if (is_sgn && cfg.format_flags[FL_SPACE]) begin
              plen <= 2'd1; pre0 <= " ";
            end else if (!is_sgn && cfg.format_flags[FL_SHARP] && radix == 5'd16 && v != 0)
            begin
              plen <= 2'd2; pre0 <= "0"; pre1 <= upper ? "X" : "x";
            end
          end
          mag_zero <= (v & mask) == 0;
          ndig <= '0;
          state <= S_DIG;
        end
        S_DIG: begin
          if ((mag == 0 && prec == 0) || ndig == NDIG_W'(DIG_MAX)) state <= S_PLAN;
          else if (radix == 5'd10) begin
            div_start <= 1'b1;
            state <= S_WAIT;
          end else begin
            digs[ndig] <= digit_char(fast_dig, upper);
            ndig <= ndig + NDIG_W'(1);
            quo <= fast_q;
            if (fast_q == 0) state <= S_PLAN;
          end
        end
        S_WAIT: if (div_done) begin
          digs[ndig] <= digit_char(div_r, upper);
          ndig <= ndig + NDIG_W'(1);
          quo <= div_q;
          state <= (div_q == 0) ? S_PLAN : S_DIG;
        end
        S_PLAN: begin
          zeros <= zero_pad ? zeros_c + pad_c : zeros_c;
          pad <= zero_pad ? '0 : pad_c;
          total <= zero_pad ? len_c + pad_c : len_c + pad_c;
          pos <= '0;
          dpos <= ndig;
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          is_empty <= (total == 0);
          is_last <= (total == 0) || (pos + CNT_W'(1) == total);
          if (total == 0) out_char <= 8'd0;
          else if (!minus && pos < pad) out_char <= " ";
          else if (pos < (minus ? '0 : pad) + CNT_W'(plen))
            out_char <= (pos == (minus ? '0 : pad)) ? pre0 : pre1;
          else if (pos < (minus ? '0 : pad) + CNT_W'(plen) + zeros) out_char <= "0";
          else if (dpos != 0) begin
            out_char <= digs[dpos - NDIG_W'(1)];
            dpos <= dpos - NDIG_W'(1);
          end else out_char <= " ";
          pos <= pos + CNT_W'(1);
          if ((total == 0) || (pos + CNT_W'(1) == total)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/ipf_checker.sv -----
// Port-level checks on the formatter's start/busy and result strobe behavior.
// Depends on integer_printf_formatter_core (bound to it).
module ipf_port_checks (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic is_empty,
  input logic is_last
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted value did not raise busy");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last) |-> busy) else $error("result strobe outside a transaction");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_empty) |-> is_last) else $error("empty text not marked last");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |-> !busy) else $error("busy after last character");
endmodule

bind integer_printf_formatter_core ipf_port_checks u_ipf_port_checks (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .is_empty(is_empty), .is_last(is_last)
);

// ----- sim/ipf_checker.sv -----
// Checker for the integer printf formatter: tracks config writes, predicts the
// character stream of every accepted value and compares it with the strobed output.
// Depends on ipf_pkg.
module ipf_checker import ipf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [VAL_W-1:0] value,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [5:0]       cfg_data,
  input  logic             strobe,
  input  logic [7:0]       out_char,
  input  logic             is_empty,
  input  logic             is_last,
  output int               errors,
  output int               pending,
  output int               values_seen,
  output int               chars_seen
);

  typedef struct packed {
    logic [7:0] ch;
    logic       empty;
    logic       last;
  } glyph_t;

  glyph_t text_q[$];
  cfg_t   fmt;

  function automatic logic [7:0] glyph_of(input int d, input logic upper);
    if (d < 10) return 8'(48 + d);
    return upper ? 8'(55 + d) : 8'(87 + d);
  endfunction

  // Expected characters of one value under the current format
  function automatic void format_value(input logic [63:0] raw);
    logic [2:0]  kind;
    logic        is_signed, upper, neg, minus, zpad, sharp;
    logic [63:0] rdx, mask, sbit, v, mag, t;
    int          prec, wid, plen, ndig, zeros, len, pad, n, i;
    logic [7:0]  pre [2];
    logic [7:0]  dig [24];
    logic [7:0]  txt [64];
    glyph_t      g;
    kind = (fmt.conversion <= CONV_XU) ? fmt.conversion : CONV_U;
    is_signed = (kind == CONV_D) || (kind == CONV_I);
    rdx = (kind == CONV_O) ? 64'd8 : ((kind >= CONV_X) ? 64'd16 : 64'd10);
    upper = (kind == CONV_XU);
    minus = fmt.format_flags[FL_MINUS];
    sharp = fmt.format_flags[FL_SHARP];
    zpad = fmt.format_flags[FL_ZERO] && !minus && !fmt.precision_given;
    if (fmt.length_modifier == LEN_INT) begin
      mask = 64'hFFFF_FFFF; sbit = 64'h8000_0000;
    end else if (fmt.length_modifier == LEN_H) begin
      mask = 64'hFFFF; sbit = 64'h8000;
    end else begin
      mask = '1; sbit = 64'h8000_0000_0000_0000;
    end
    prec = fmt.precision_given ? int'(fmt.precision) : 1;
    if (prec > MAX_FIELD) prec = MAX_FIELD;
    wid = int'(fmt.field_width);
    if (wid > MAX_FIELD) wid = MAX_FIELD;
    v = raw & mask;
    mag = v;
    neg = 1'b0;
    if (is_signed && (v & sbit) != 0) begin
      neg = 1'b1;
      mag = (~v + 64'd1) & mask;
    end
    // sign or hex prefix
    plen = 0;
    if (is_signed) begin
      if (neg) begin pre[0] = "-"; plen = 1; end
      else if (fmt.format_flags[FL_PLUS]) begin pre[0] = "+"; plen = 1; end
      else if (fmt.format_flags[FL_SPACE]) begin pre[0] = " "; plen = 1; end
    end else if (sharp && rdx == 16 && mag != 0) begin
      pre[0] = "0"; pre[1] = upper ? "X" : "x"; plen = 2;
    end
    // digits, least significant first
    ndig = 0;
    if (!(mag == 0 && prec == 0)) begin
      t = mag;
      do begin
        dig[ndig] = glyph_of(int'(t % rdx), upper);
        ndig++;
        t = t / rdx;
      end while (t != 0 && ndig < 24);
    end
    zeros = (prec > ndig) ? prec - ndig : 0;
    if (sharp && rdx == 8 && !is_signed)
      if (!(zeros > 0 || (ndig > 0 && mag == 0))) zeros++;
    len = plen + zeros + ndig;
    pad = (wid > len) ? wid - len : 0;
    if (zpad) begin zeros += pad; pad = 0; end
    n = 0;
    if (!minus) for (i = 0; i < pad; i++) begin txt[n] = " "; n++; end
    for (i = 0; i < plen; i++) begin txt[n] = pre[i]; n++; end
    for (i = 0; i < zeros; i++) begin txt[n] = "0"; n++; end
    for (i = ndig; i > 0; i--) begin txt[n] = dig[i-1]; n++; end
    if (minus) for (i = 0; i < pad; i++) begin txt[n] = " "; n++; end
    if (n == 0) begin
      g.ch = 8'd0; g.empty = 1'b1; g.last = 1'b1;
      text_q.push_back(g);
    end else begin
      for (i = 0; i < n; i++) begin
        g.ch = txt[i]; g.empty = 1'b0; g.last = (i == n - 1);
        text_q.push_back(g);
      end
    end
  endfunction

  always @(posedge clk) begin
    glyph_t e;
    if (rst) begin
      fmt <= '{conversion: CONV_D, length_modifier: LEN_INT, format_flags: 5'd0,
               field_width: 6'd0, precision: 6'd1, precision_given: 1'b0};
      text_q.delete();
      errors <= 0;
      values_seen <= 0;
      chars_seen <= 0;
      pending = 0;
    end else begin
      // output transaction against the oldest expected character
      if (strobe) begin
        chars_seen <= chars_seen + 1;
        if (text_q.size() == 0) begin
          if (errors < 10)
            $display("[%0t] unexpected character %h empty=%b last=%b",
                     $realtime, out_char, is_empty, is_last);
          errors <= errors + 1;
        end else begin
          e = text_q.pop_front();
          if (is_empty !== e.empty || is_last !== e.last ||
              (!e.empty && out_char !== e.ch)) begin
            if (errors < 10)
              $display("[%0t] mismatch: expected char %h empty %b last %b, got %h %b %b",
                       $realtime, e.ch, e.empty, e.last, out_char, is_empty, is_last);
            errors <= errors + 1;
          end
        end
      end
      // config write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CONV:   fmt.conversion <= cfg_data[2:0];
          REG_LEN:    fmt.length_modifier <= cfg_data[1:0];
          REG_FLAGS:  fmt.format_flags <= cfg_data[4:0];
          REG_WIDTH:  fmt.field_width <= cfg_data;
          REG_PREC:   fmt.precision <= cfg_data;
          REG_PGIVEN: fmt.precision_given <= cfg_data[0];
          default: ;
        endcase
      end
      // value transaction
      if (start && !busy) begin
        format_value(value);
        values_seen <= values_seen + 1;
      end
      pending = text_q.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the integer printf formatter testbench: clock, reset, stimulus, verdict.
// Depends on ipf_pkg, integer_printf_formatter_core and ipf_checker.
module testbench;
  import ipf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic             clk, rst, start, busy;
  logic [VAL_W-1:0] value;
  logic             cfg_valid, cfg_ready;
  logic [2:0]       cfg_index;
  logic [5:0]       cfg_data;
  logic             strobe, is_empty, is_last;
  logic [7:0]       out_char;
  int               errors, pending, values_seen, chars_seen;
  int               cycles = 0;
  logic             calm;

  integer_printf_formatter_core dut (
    .clk, .rst, .start, .busy, .value, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .strobe, .out_char, .is_empty, .is_last
  );

  ipf_checker chk (
    .clk, .rst, .start, .busy, .value, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .strobe, .out_char, .is_empty, .is_last,
    .errors, .pending, .values_seen, .chars_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // random sender gap, none in the final stretch
  task automatic sender_gap();
    int g;
    if (calm || $urandom_range(0, 3) != 0) return;
    g = $urandom_range(1, 9);
    start <= 1'b0;
    repeat (g) @(negedge clk);
  endtask

  // one value transaction; start stays high afterwards unless a gap follows
  task automatic send_value(input logic [63:0] v);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sender_gap();
  endtask

  // drain the block before touching the registers
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
  endtask

  task automatic set_format(input logic [2:0] cv, input logic [1:0] ln, input logic [4:0] fl,
                            input logic [5:0] w, input logic [5:0] p, input logic pg);
    settle();
    write_reg(REG_CONV, {3'd0, cv});
    write_reg(REG_LEN, {4'd0, ln});
    write_reg(REG_FLAGS, {1'b0, fl});
    write_reg(REG_WIDTH, w);
    write_reg(REG_PREC, p);
    write_reg(REG_PGIVEN, {5'd0, pg});
  endtask

  function automatic logic [5:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 6'($urandom_range(40, 63));
      1, 2: return 6'd0;
      default: return 6'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r;
      1: return 64'($urandom_range(0, 20));
      2: return r ^ (64'd1 << $urandom_range(0, 63));
      3: return {r[63:32], 1'b1, 15'd0, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF};
      4: return $urandom_range(0, 1) ? 64'd0 : '1;
      default: return r >> $urandom_range(1, 60);
    endcase
  endfunction

  initial begin
    int ph, k;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CONV;
    cfg_data = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset format: %d, 32-bit
    send_value(64'd0);
    send_value(64'h0000_0000_8000_0000);
    send_value('1);
    send_value(64'h1234_5678_7FFF_FFFF);
    // empty text and zero-precision cases
    set_format(CONV_U, LEN_INT, 5'd0, 6'd0, 6'd0, 1'b1);
    send_value(64'd0);
    set_format(CONV_O, LEN_INT, 5'b01000, 6'd0, 6'd0, 1'b1);
    send_value(64'd0);
    send_value(64'o17);
    // hex prefix and zero padding after it
    set_format(CONV_X, 2'd2, 5'b11000, 6'd12, 6'd1, 1'b0);
    send_value(64'd0);
    send_value(64'hDEAD_BEEF_CAFE_F00D);
    set_format(CONV_XU, 2'd2, 5'b01000, 6'd20, 6'd1, 1'b0);
    send_value(64'h0ABC);
    // plus over space, sharp ignored on signed
    set_format(CONV_I, LEN_H, 5'b01110, 6'd0, 6'd1, 1'b0);
    send_value(64'h8000);
    send_value(64'h7FFF);
    // minus over zero, left justified
    set_format(CONV_D, LEN_INT, 5'b10101, 6'd10, 6'd1, 1'b0);
    send_value(64'd42);
    send_value(64'hFFFF_FFFF);
    // zero flag dropped for explicit precision, unused length code
    set_format(CONV_D, 2'd3, 5'b10000, 6'd30, 6'd5, 1'b1);
    send_value(64'h8000_0000_0000_0000);
    // unused conversion code, oversize width and precision
    set_format(3'd7, 2'd2, 5'b00110, 6'd63, 6'd63, 1'b1);
    send_value('1);
    set_format(CONV_O, LEN_H, 5'b11000, 6'd63, 6'd1, 1'b0);
    send_value(64'h1FFFF);
    // out-of-range register index is ignored
    settle();
    write_reg(3'd6, 6'h3F);
    write_reg(3'd7, 6'h15);
    send_value(64'd8);

    // random formats, a batch of values each
    for (ph = 0; ph < 16; ph++) begin
      if (ph >= 13) calm = 1'b1;
      set_format(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 5'($urandom),
                 pick_size(), pick_size(), 1'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(6, 7)), 6'($urandom));
      for (k = 0; k < 10; k++) send_value(pick_value());
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    $display("Covered %0d values and %0d characters over all conversions, lengths,",
             values_seen, chars_seen);
    $display("flag mixes and width/precision settings up to saturation; %0d errors.", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
